// ===== rtl/core/gregorian_date_arithmetic_defines.svh =====
// assertion macros for the gregorian date arithmetic block
// used by the top level, which supplies clk and arst_n in scope
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define GDA_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("gda check failed");

// condition that must hold whenever the antecedent holds
`define GDA_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gda implication failed");

`endif

// ===== rtl/core/gda_pkg.sv =====
// shared types, constants and calendar helpers for the date arithmetic block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package gda_pkg;

	// action codes
	localparam logic [2:0] ACT_CHECK  = 3'd0;
	localparam logic [2:0] ACT_DAYS   = 3'd1;
	localparam logic [2:0] ACT_MONTHS = 3'd2;
	localparam logic [2:0] ACT_YEARS  = 3'd3;
	localparam logic [2:0] ACT_CMP    = 3'd4;

	// order codes
	localparam logic [1:0] ORD_EQUAL = 2'b00;
	localparam logic [1:0] ORD_LATER = 2'b01;
	localparam logic [1:0] ORD_EARLY = 2'b11;

	// port widths
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 40;

	// calendar limits, day numbers counted from 0000-03-01
	localparam logic [13:0] MAX_YEAR  = 14'd9999;
	localparam logic [3:0]  MONTHS    = 4'd12;
	localparam logic [21:0] SERIAL_LO = 22'd306;
	localparam logic [21:0] SERIAL_HI = 22'd3652364;
	localparam logic [21:0] DAYS_ERA  = 22'd146097;
	localparam logic [17:0] DAYS_CENT = 18'd36524;
	localparam logic [17:0] ERA_LAST  = 18'd146096;

	// rounded-up reciprocals, exact over the operand ranges used
	localparam logic [25:0] RCP_100  = 26'(((64'd1 << 32) + 64'd99) / 64'd100);
	localparam logic [28:0] RCP_12   = 29'(((64'd1 << 32) + 64'd11) / 64'd12);
	localparam logic [26:0] RCP_ERA  = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
	localparam logic [29:0] RCP_1460 = 30'(((64'd1 << 40) + 64'd1459) / 64'd1460);
	localparam logic [31:0] RCP_365  = 32'(((64'd1 << 40) + 64'd364) / 64'd365);
	localparam logic [13:0] RCP_7    = 14'(((64'd1 << 16) + 64'd6) / 64'd7);

	typedef struct packed {
		logic [2:0]  action;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [22:0] amount;
		logic [13:0] cmp_year;
		logic [3:0]  cmp_month;
		logic [4:0]  cmp_day;
	} in_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	// item state between front end, day conversion and back end
	typedef struct packed {
		logic [2:0]  action;
		logic        valid;
		logic [1:0]  order;
		date_t       date;
		logic [21:0] z;
	} item_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic        leap;
		logic [4:0]  mlen;
		logic        valid;
		logic [1:0]  order;
	} res_t;

	function automatic logic [13:0] clamp_year(input logic [13:0] v);
		if (v == 14'd0)
			return 14'd1;
		if (v > MAX_YEAR)
			return MAX_YEAR;
		return v;
	endfunction

	function automatic logic [3:0] clamp_month(input logic [3:0] v);
		if (v == 4'd0)
			return 4'd1;
		if (v > MONTHS)
			return MONTHS;
		return v;
	endfunction

	// v / 100 for v up to 9999
	function automatic logic [6:0] div100(input logic [13:0] v);
		logic [39:0] p;
		p = 40'(v) * 40'(RCP_100);
		return p[38:32];
	endfunction

	// leap test from the year and its hundreds quotient
	function automatic logic leap_of(input logic [13:0] v, input logic [6:0] q);
		logic [13:0] r;
		r = v - ({7'd0, q} * 14'd100);
		return (r == 14'd0) ? (q[1:0] == 2'd0) : (v[1:0] == 2'd0);
	endfunction

	function automatic logic [4:0] mdays(input logic [3:0] m, input logic leap);
		case (m)
			4'd2:    return leap ? 5'd29 : 5'd28;
			4'd4:    return 5'd30;
			4'd6:    return 5'd30;
			4'd9:    return 5'd30;
			4'd11:   return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	// first day of a month in the march-based year
	function automatic logic [8:0] mstart(input logic [3:0] m);
		case (m)
			4'd3:    return 9'd0;
			4'd4:    return 9'd31;
			4'd5:    return 9'd61;
			4'd6:    return 9'd92;
			4'd7:    return 9'd122;
			4'd8:    return 9'd153;
			4'd9:    return 9'd184;
			4'd10:   return 9'd214;
			4'd11:   return 9'd245;
			4'd12:   return 9'd275;
			4'd1:    return 9'd306;
			default: return 9'd337;
		endcase
	endfunction

	// zeller month term, january and february as months 13 and 14
	function automatic logic [5:0] zterm(input logic [3:0] m);
		case (m)
			4'd1:    return 6'd36;
			4'd2:    return 6'd39;
			4'd3:    return 6'd10;
			4'd4:    return 6'd13;
			4'd5:    return 6'd15;
			4'd6:    return 6'd18;
			4'd7:    return 6'd20;
			4'd8:    return 6'd23;
			4'd9:    return 6'd26;
			4'd10:   return 6'd28;
			4'd11:   return 6'd31;
			default: return 6'd33;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gda_front.sv =====
// front end: clamps the dates, checks validity, applies month and year steps,
// forms the clamped day number for day steps and orders compares; depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none
module gda_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  gda_pkg::in_t  in_word,
	output logic          item_valid,
	output gda_pkg::item_t item
);
	import gda_pkg::*;

	typedef struct packed {
		logic [2:0]  action;
		logic [22:0] amt;
		logic [4:0]  id;
		logic [4:0]  cd;
		logic        yrange;
		logic        mrange;
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		logic [13:0] cy;
		logic [3:0]  cm;
		logic [4:0]  cdc;
		logic [13:0] yy;
		logic [6:0]  qy;
		logic [6:0]  qcy;
		logic [6:0]  qyy;
		logic        neg;
		logic [22:0] mag;
		logic [18:0] qmag;
		logic [3:0]  rmag;
		logic [23:0] ny;
		logic [13:0] nyc;
		logic [6:0]  qny;
		logic        leapny;
		logic        valid;
		logic [21:0] spart;
	} fwork_t;

	fwork_t n1, n2, w_s1, w_s2;
	item_t  n3, item_s3;
	logic   v_s1, v_s2, v_s3;

	logic [51:0] prod_m;
	logic        lp, clp;
	logic [4:0]  ml, cml;
	logic [22:0] mag_rem;
	logic [21:0] serial;
	logic [24:0] zs;
	logic [21:0] ny2;
	logic [5:0]  nm;

	// stage 1: clamp fields, hundreds quotients, month split, year sum
	always_comb begin
		n1 = '0;
		n1.action = in_word.action;
		n1.amt = in_word.amount;
		n1.id = in_word.day;
		n1.cd = in_word.cmp_day;
		n1.yrange = (in_word.year != 14'd0) && (in_word.year <= MAX_YEAR);
		n1.mrange = (in_word.month != 4'd0) && (in_word.month <= MONTHS);
		n1.y = clamp_year(in_word.year);
		n1.m = clamp_month(in_word.month);
		n1.cy = clamp_year(in_word.cmp_year);
		n1.cm = clamp_month(in_word.cmp_month);
		n1.yy = n1.y - ((n1.m <= 4'd2) ? 14'd1 : 14'd0);
		n1.qy = div100(n1.y);
		n1.qcy = div100(n1.cy);
		n1.qyy = div100(n1.yy);
		n1.neg = in_word.amount[22];
		n1.mag = n1.neg ? (~in_word.amount + 23'd1) : in_word.amount;
		prod_m = 52'(n1.mag) * 52'(RCP_12);
		n1.qmag = prod_m[50:32];
		n1.ny = $signed({10'd0, n1.y}) + $signed({in_word.amount[22], in_word.amount});
		if ($signed(n1.ny) < 24'sd1)
			n1.nyc = 14'd1;
		else if ($signed(n1.ny) > 24'sd9999)
			n1.nyc = MAX_YEAR;
		else
			n1.nyc = n1.ny[13:0];
		n1.qny = div100(n1.nyc);
	end

	// stage 2: leap years, day clamp, validity, month remainder, day number
	always_comb begin
		n2 = w_s1;
		lp = leap_of(w_s1.y, w_s1.qy);
		ml = mdays(w_s1.m, lp);
		n2.d = (w_s1.id == 5'd0) ? 5'd1 : ((w_s1.id > ml) ? ml : w_s1.id);
		n2.valid = w_s1.yrange && w_s1.mrange && (w_s1.id != 5'd0) && (w_s1.id <= ml);
		clp = leap_of(w_s1.cy, w_s1.qcy);
		cml = mdays(w_s1.cm, clp);
		n2.cdc = (w_s1.cd == 5'd0) ? 5'd1 : ((w_s1.cd > cml) ? cml : w_s1.cd);
		mag_rem = w_s1.mag - ({4'd0, w_s1.qmag} * 23'd12);
		n2.rmag = mag_rem[3:0];
		n2.leapny = ($signed(w_s1.ny) >= 24'sd1) && ($signed(w_s1.ny) <= 24'sd9999) &&
			leap_of(w_s1.nyc, w_s1.qny);
		n2.spart = ({8'd0, w_s1.yy} * 22'd365) + 22'(w_s1.yy >> 2) - 22'(w_s1.qyy) +
			22'(w_s1.qyy >> 2) + 22'(mstart(w_s1.m)) - 22'd1;
	end

	// stage 3: saturated day number and the results of the other actions
	always_comb begin
		n3 = '0;
		n3.action = w_s2.action;
		n3.valid = w_s2.valid;
		serial = w_s2.spart + 22'(w_s2.d);
		zs = $signed({3'd0, serial}) + $signed({{2{w_s2.amt[22]}}, w_s2.amt});
		if ($signed(zs) < $signed({3'd0, SERIAL_LO}))
			n3.z = SERIAL_LO;
		else if ($signed(zs) > $signed({3'd0, SERIAL_HI}))
			n3.z = SERIAL_HI;
		else
			n3.z = zs[21:0];

		// month step with borrow and carry into the year
		if (w_s2.neg) begin
			ny2 = {8'd0, w_s2.y} - {3'd0, w_s2.qmag};
			nm = {2'd0, w_s2.m} - {2'd0, w_s2.rmag};
		end else begin
			ny2 = {8'd0, w_s2.y} + {3'd0, w_s2.qmag};
			nm = {2'd0, w_s2.m} + {2'd0, w_s2.rmag};
		end
		if ($signed(nm) <= 6'sd0) begin
			ny2 = ny2 - 22'd1;
			nm = nm + 6'd12;
		end else if ($signed(nm) > 6'sd12) begin
			ny2 = ny2 + 22'd1;
			nm = nm - 6'd12;
		end

		n3.date = '{year: w_s2.y, month: w_s2.m, day: w_s2.d};
		case (w_s2.action)
			ACT_MONTHS: begin
				if ($signed(ny2) < 22'sd1)
					n3.date = '{year: 14'd1, month: 4'd1, day: 5'd1};
				else if ($signed(ny2) > 22'sd9999)
					n3.date = '{year: MAX_YEAR, month: MONTHS, day: 5'd31};
				else
					n3.date = '{year: ny2[13:0], month: nm[3:0], day: w_s2.d};
			end
			ACT_YEARS: begin
				// feb 29 moves to mar 1 when the new year is not leap
				if (w_s2.m == 4'd2 && w_s2.d == 5'd29 && !w_s2.leapny)
					n3.date = '{year: w_s2.nyc, month: 4'd3, day: 5'd1};
				else
					n3.date = '{year: w_s2.nyc, month: w_s2.m, day: w_s2.d};
			end
			default: begin
				n3.date = '{year: w_s2.y, month: w_s2.m, day: w_s2.d};
			end
		endcase

		// clamped dates order the same way as their fields
		if (w_s2.action == ACT_CMP) begin
			if ({w_s2.y, w_s2.m, w_s2.d} > {w_s2.cy, w_s2.cm, w_s2.cdc})
				n3.order = ORD_LATER;
			else if ({w_s2.y, w_s2.m, w_s2.d} < {w_s2.cy, w_s2.cm, w_s2.cdc})
				n3.order = ORD_EARLY;
			else
				n3.order = ORD_EQUAL;
		end else begin
			n3.order = ORD_EQUAL;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= n1;
			w_s2 <= n2;
			item_s3 <= n3;
		end
	end

	assign item_valid = v_s3;
	assign item = item_s3;

endmodule
`default_nettype wire

// ===== rtl/core/gda_days.sv =====
// day number to calendar date conversion, seven register stages
// carries the front-end item alongside; depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none
module gda_days (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           item_in_valid,
	input  gda_pkg::item_t item_in,
	output logic           item_valid,
	output gda_pkg::item_t item,
	output gda_pkg::date_t conv
);
	import gda_pkg::*;

	typedef struct packed {
		item_t       it;
		logic [4:0]  era;
		logic [17:0] doe;
		logic [6:0]  q1460;
		logic [2:0]  q36;
		logic        isend;
		logic [17:0] n;
		logic [8:0]  yoe;
		logic [8:0]  doy;
		date_t       dt;
	} dwork_t;

	dwork_t n4, n5, n6, n7, n8, n9, n10;
	dwork_t w_s4, w_s5, w_s6, w_s7, w_s8, w_s9, w_s10;
	logic   v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic [48:0] prod_era;
	logic [21:0] era_days;
	logic [47:0] prod_1460;
	logic [49:0] prod_365;
	logic [1:0]  c100;
	logic [17:0] doy_full;
	logic [3:0]  mon, sel_m;
	logic [8:0]  sel_s;

	// stage 4: 400-year era index
	always_comb begin
		n4 = '0;
		n4.it = item_in;
		prod_era = 49'(item_in.z) * 49'(RCP_ERA);
		n4.era = prod_era[48:44];
	end

	// stage 5: day of era
	always_comb begin
		n5 = w_s4;
		era_days = {17'd0, w_s4.era} * DAYS_ERA;
		n5.doe = 18'(w_s4.it.z - era_days);
	end

	// stage 6: four-year and century corrections
	always_comb begin
		n6 = w_s5;
		prod_1460 = 48'(w_s5.doe) * 48'(RCP_1460);
		n6.q1460 = prod_1460[46:40];
		n6.q36 = 3'(w_s5.doe >= DAYS_CENT) + 3'(w_s5.doe >= 18'(DAYS_CENT * 2)) +
			3'(w_s5.doe >= 18'(DAYS_CENT * 3)) + 3'(w_s5.doe >= ERA_LAST);
		n6.isend = (w_s5.doe == ERA_LAST);
	end

	// stage 7: day count with leap days removed
	always_comb begin
		n7 = w_s6;
		n7.n = w_s6.doe - 18'(w_s6.q1460) + 18'(w_s6.q36) - 18'(w_s6.isend);
	end

	// stage 8: year of era
	always_comb begin
		n8 = w_s7;
		prod_365 = 50'(w_s7.n) * 50'(RCP_365);
		n8.yoe = prod_365[48:40];
	end

	// stage 9: day of the march-based year
	always_comb begin
		n9 = w_s8;
		c100 = (w_s8.yoe >= 9'd300) ? 2'd3 : ((w_s8.yoe >= 9'd200) ? 2'd2 :
			((w_s8.yoe >= 9'd100) ? 2'd1 : 2'd0));
		doy_full = w_s8.doe - (18'(w_s8.yoe) * 18'd365 + 18'(w_s8.yoe >> 2) - 18'(c100));
		n9.doy = doy_full[8:0];
	end

	// stage 10: month by threshold search, then day and year
	always_comb begin
		n10 = w_s9;
		sel_m = 4'd3;
		sel_s = 9'd0;
		for (int i = 0; i < 12; i++) begin
			mon = (i < 10) ? 4'(i + 3) : 4'(i - 9);
			if (w_s9.doy >= mstart(mon)) begin
				sel_m = mon;
				sel_s = mstart(mon);
			end
		end
		n10.dt.month = sel_m;
		n10.dt.day = 5'(w_s9.doy - sel_s + 9'd1);
		n10.dt.year = 14'(w_s9.yoe) + ({9'd0, w_s9.era} * 14'd400) +
			((sel_m <= 4'd2) ? 14'd1 : 14'd0);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s4 <= item_in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			w_s4 <= n4;
			w_s5 <= n5;
			w_s6 <= n6;
			w_s7 <= n7;
			w_s8 <= n8;
			w_s9 <= n9;
			w_s10 <= n10;
		end
	end

	assign item_valid = v_s10;
	assign item = w_s10.it;
	assign conv = w_s10.dt;

endmodule
`default_nettype wire

// ===== rtl/core/gda_back.sv =====
// back end: picks the result date, adds leap flag, month length and weekday
// last stage is the output register; depends on gda_pkg
`timescale 1ns / 1ps
`default_nettype none
module gda_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           item_in_valid,
	input  gda_pkg::item_t item_in,
	input  gda_pkg::date_t conv,
	output logic           res_valid,
	output gda_pkg::res_t  res
);
	import gda_pkg::*;

	typedef struct packed {
		logic        valid;
		logic [1:0]  order;
		date_t       dt;
		logic [6:0]  qr;
		logic [13:0] yz;
		logic [6:0]  qz;
		logic        leap;
		logic [4:0]  mlen;
		logic [9:0]  zsum;
		logic [6:0]  q7;
	} bwork_t;

	bwork_t n11, n12, n13, w_s11, w_s12, w_s13;
	res_t   n14, res_s14;
	logic   v_s11, v_s12, v_s13, v_s14;

	logic [13:0] k_full;
	logic [6:0]  k;
	logic [23:0] prod_7;
	logic [9:0]  h_full;
	logic [2:0]  h;

	// stage 11: select date, hundreds quotients for leap and zeller year
	always_comb begin
		n11 = '0;
		n11.valid = item_in.valid;
		n11.order = item_in.order;
		n11.dt = (item_in.action == ACT_DAYS) ? conv : item_in.date;
		n11.qr = div100(n11.dt.year);
		n11.yz = n11.dt.year - ((n11.dt.month <= 4'd2) ? 14'd1 : 14'd0);
		n11.qz = div100(n11.yz);
	end

	// stage 12: leap flag, month length, day clamp, zeller partial sum
	always_comb begin
		n12 = w_s11;
		n12.leap = leap_of(w_s11.dt.year, w_s11.qr);
		n12.mlen = mdays(w_s11.dt.month, n12.leap);
		if (w_s11.dt.day > n12.mlen)
			n12.dt.day = n12.mlen;
		k_full = w_s11.yz - ({7'd0, w_s11.qz} * 14'd100);
		k = k_full[6:0];
		n12.zsum = 10'(k) + 10'(k >> 2) + 10'(w_s11.qz >> 2) + (10'(w_s11.qz) * 10'd5) +
			10'(zterm(w_s11.dt.month));
	end

	// stage 13: add day, weekday quotient by seven
	always_comb begin
		n13 = w_s12;
		n13.zsum = w_s12.zsum + 10'(w_s12.dt.day);
		prod_7 = 24'(n13.zsum) * 24'(RCP_7);
		n13.q7 = prod_7[22:16];
	end

	// stage 14: weekday remainder, output word
	always_comb begin
		h_full = w_s13.zsum - (10'(w_s13.q7) * 10'd7);
		h = h_full[2:0];
		n14.year = w_s13.dt.year;
		n14.month = w_s13.dt.month;
		n14.day = w_s13.dt.day;
		n14.weekday = (h == 3'd0) ? 3'd7 : h;
		n14.leap = w_s13.leap;
		n14.mlen = w_s13.mlen;
		n14.valid = w_s13.valid;
		n14.order = w_s13.order;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s11 <= item_in_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			w_s11 <= n11;
			w_s12 <= n12;
			w_s13 <= n13;
			res_s14 <= n14;
		end
	end

	assign res_valid = v_s14;
	assign res = res_s14;

endmodule
`default_nettype wire

// ===== rtl/core/gregorian_date_arithmetic.sv =====
// Gregorian date arithmetic, fourteen-stage pipeline.
// Input stream: s_tuser carries the action (check, add days, add months,
// add years, compare); s_tdata carries the date, the signed amount and the
// second date for compare. Each accepted word gives exactly one result word
// on the output stream: resulting date, weekday (1 Sunday), leap flag,
// month length, input validity and compare order.
// One word can enter every cycle; the fourteen stages run under one
// shared enable, so throughput is one word per cycle while the receiver
// takes words.
// When the receiver holds m_tready low with a word waiting, the whole
// pipeline stops and s_tready drops in the same cycle; nothing is lost or
// repeated and the waiting word stays unchanged.
// Reset clears every stage valid bit; the block accepts words in the first
// cycle after arst_n is released.
// Depends on gda_pkg, gda_front, gda_days, gda_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "gregorian_date_arithmetic_defines.svh"
module gregorian_date_arithmetic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// year, month, day, amount, cmp_year, cmp_month, cmp_day, zero pad
	input  logic [gda_pkg::IN_DATA_W-1:0]    s_tdata,
	// action
	input  logic [2:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// res_year, res_month, res_day, weekday, leap_flag, month_length,
	// date_valid, order, zero pad
	output logic [gda_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import gda_pkg::*;

	logic  en;
	in_t   in_word;
	logic  front_valid, days_valid;
	item_t front_item, days_item;
	date_t conv;
	res_t  res;

	// one enable for all stages: advance unless a result is stuck
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// unpack the input word
	always_comb begin
		in_word.action = s_tuser;
		in_word.year = s_tdata[13:0];
		in_word.month = s_tdata[17:14];
		in_word.day = s_tdata[22:18];
		in_word.amount = s_tdata[45:23];
		in_word.cmp_year = s_tdata[59:46];
		in_word.cmp_month = s_tdata[63:60];
		in_word.cmp_day = s_tdata[68:64];
	end

	gda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_word    (in_word),
		.item_valid (front_valid),
		.item       (front_item)
	);

	gda_days u_days (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.item_in_valid (front_valid),
		.item_in       (front_item),
		.item_valid    (days_valid),
		.item          (days_item),
		.conv          (conv)
	);

	gda_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.item_in_valid (days_valid),
		.item_in       (days_item),
		.conv          (conv),
		.res_valid     (m_tvalid),
		.res           (res)
	);

	// pack the result word
	assign m_tdata = {5'd0, res.order, res.valid, res.mlen, res.leap, res.weekday,
		res.day, res.month, res.year};

	// result sanity
	`GDA_IMPLY(a_day_fits, m_tvalid, res.day != 5'd0 && res.day <= res.mlen)
	`GDA_IMPLY(a_feb_len, m_tvalid && res.month == 4'd2, res.mlen == (res.leap ? 5'd29 : 5'd28))
	`GDA_IMPLY(a_year_range, m_tvalid, res.year != 14'd0 && res.year <= MAX_YEAR)
	`GDA_CHECK(a_order_code, !m_tvalid || res.order != 2'b10)

endmodule
`default_nettype wire
